@@ hw/rtl/msr_pkg.sv @@
// Shared types and codes for the smoothstep setpoint ramp.
// Used by msr_ctrl, msr_dp and motion_setpoint_smoothstep_ramp. No dependencies.
`timescale 1ns / 1ps
package msr_pkg;

	localparam logic [1:0] FUNC_ABS   = 2'd0;
	localparam logic [1:0] FUNC_NORM  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_ESTOP = 2'd3;

	localparam logic [2:0] CFG_ENABLED  = 3'd0;
	localparam logic [2:0] CFG_GYRO     = 3'd1;
	localparam logic [2:0] CFG_MAX_P    = 3'd2;
	localparam logic [2:0] CFG_MAX_R    = 3'd3;
	localparam logic [2:0] CFG_MAX_F    = 3'd4;
	localparam logic [2:0] CFG_MAX_V    = 3'd5;

	localparam logic [30:0] LIM_ROT_RST   = 31'd983040;
	localparam logic [30:0] LIM_TRANS_RST = 31'd655360;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] pitch_in;
		logic signed [31:0] roll_in;
		logic signed [31:0] forward_in;
		logic signed [31:0] vertical_in;
		logic [25:0]        duration_us;
		logic               continuous;
		logic [19:0]        elapsed_us;
	} in_t;

	typedef struct packed {
		logic signed [31:0] cur_pitch;
		logic signed [31:0] cur_roll;
		logic signed [31:0] cur_forward;
		logic signed [31:0] cur_vertical;
		logic signed [31:0] tgt_pitch;
		logic signed [31:0] tgt_roll;
		logic signed [31:0] tgt_forward;
		logic signed [31:0] tgt_vertical;
		logic               moving;
		logic               ignored;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SCL_M, S_SCL_W, S_NFIN, S_DIV,
		S_SQ_M, S_SQ_W, S_CB_M, S_CB_W, S_LRP_M, S_LRP_W, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ABS, OP_SCL_MUL, OP_SCL_WR, OP_NORM_FIN,
		OP_ESTOP, OP_SNAP, OP_SUB, OP_DIV, OP_SQ_MUL, OP_SQ_WR,
		OP_CB_MUL, OP_CB_WR, OP_LRP_MUL, OP_LRP_WR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic       ign;
		logic [1:0] func;
		logic       tl_zero;
		logic       expire;
	} sts_t;

endpackage

@@ hw/rtl/motion_setpoint_smoothstep_ramp.sv @@
// Four-axis setpoint generator with smoothstep ramp. One item in flight at a time;
// a ramping tick runs the one-bit-per-cycle alpha divider and then the shared
// multiplier, which serves the squaring, the cubic term and each of the four axes
// in turn. The result sits in an output register, so the next item is taken while
// it waits. Depends on msr_pkg.
`timescale 1ns / 1ps
module motion_setpoint_smoothstep_ramp import msr_pkg::*; #(
	parameter int MIN_DURATION_US = 10000,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [30:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cmd_t cmd;
	sts_t sts;
	out_t res;
	logic emit, out_free, out_valid_q;
	out_t out_q;

	assign out_free = !out_valid_q || out_ready;

	msr_ctrl #(.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_free(out_free), .emit(emit), .sts(sts), .cmd(cmd)
	);

	msr_dp #(.MIN_DURATION_US(MIN_DURATION_US), .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .in_data(in_data), .cmd(cmd), .sts(sts), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/msr_ctrl.sv @@
// Sequencer for the setpoint ramp: decodes each transfer and steps the datapath.
// Depends on msr_pkg.
`timescale 1ns / 1ps
module msr_ctrl import msr_pkg::*; #(
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_free,
	output logic emit,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CW = $clog2(ALPHA_FRAC_BITS + 2);
	localparam logic [CW-1:0] DIV_LAST = CW'(ALPHA_FRAC_BITS);
	localparam logic [CW-1:0] AX_LAST  = CW'(3);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DEC;
			S_DEC: begin
				if (sts.ign) begin
					state_d = S_DONE;
				end else begin
					case (sts.func)
						FUNC_NORM: state_d = S_SCL_M;
						FUNC_TICK: state_d = (sts.tl_zero || sts.expire) ? S_DONE : S_DIV;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_SCL_M: state_d = S_SCL_W;
			S_SCL_W: state_d = (cnt_q == AX_LAST) ? S_NFIN : S_SCL_M;
			S_NFIN:  state_d = S_DONE;
			S_DIV:   if (cnt_q == DIV_LAST) state_d = S_SQ_M;
			S_SQ_M:  state_d = S_SQ_W;
			S_SQ_W:  state_d = S_CB_M;
			S_CB_M:  state_d = S_CB_W;
			S_CB_W:  state_d = S_LRP_M;
			S_LRP_M: state_d = S_LRP_W;
			S_LRP_W: state_d = (cnt_q == AX_LAST) ? S_DONE : S_LRP_M;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.axis = cnt_q[1:0];
		in_ready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_DEC: begin
				if (!sts.ign) begin
					case (sts.func)
						FUNC_ABS:   cmd.op = OP_ABS;
						FUNC_ESTOP: cmd.op = OP_ESTOP;
						FUNC_TICK: begin
							if (sts.tl_zero)     cmd.op = OP_NONE;
							else if (sts.expire) cmd.op = OP_SNAP;
							else                 cmd.op = OP_SUB;
						end
						default: cmd.op = OP_NONE;
					endcase
				end
			end
			S_SCL_M: cmd.op = OP_SCL_MUL;
			S_SCL_W: cmd.op = OP_SCL_WR;
			S_NFIN:  cmd.op = OP_NORM_FIN;
			S_DIV:   cmd.op = OP_DIV;
			S_SQ_M:  cmd.op = OP_SQ_MUL;
			S_SQ_W:  cmd.op = OP_SQ_WR;
			S_CB_M:  cmd.op = OP_CB_MUL;
			S_CB_W:  cmd.op = OP_CB_WR;
			S_LRP_M: cmd.op = OP_LRP_MUL;
			S_LRP_W: cmd.op = OP_LRP_WR;
			S_DONE:  emit = out_free;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DEC:   cnt_q <= '0;
				S_SCL_W, S_DIV, S_LRP_W: cnt_q <= cnt_q + CW'(1);
				S_CB_W:  cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider ran past its last step");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (state_q == S_IDLE))
		else $error("no return to idle after result");
	a_ign_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && sts.ign) |=> (state_q == S_DONE))
		else $error("dropped item did not finish at once");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DEC))
		else $error("transfer not decoded");

endmodule

@@ hw/rtl/msr_dp.sv @@
// Datapath for the setpoint ramp: config, axis state, shared multiplier, divider.
// Depends on msr_pkg; driven by msr_ctrl commands.
`timescale 1ns / 1ps
module msr_dp import msr_pkg::*; #(
	parameter int MIN_DURATION_US = 10000,
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [30:0] cfg_wdata,
	input  in_t         in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output out_t        res
);

	localparam int AF = ALPHA_FRAC_BITS;
	localparam int AW = AF + 1;
	localparam logic [AW-1:0] ONE   = {1'b1, {AF{1'b0}}};
	localparam logic [AW:0]   THREE = {2'b11, {AF{1'b0}}};
	localparam logic [63:0]   HALF  = 64'd1 << (AF - 1);
	localparam logic [25:0]   MIN_DUR = 26'(MIN_DURATION_US);

	logic               en_q, gyro_q, ign_q;
	logic [30:0]        lim_q [4];
	logic signed [31:0] cur_q [4];
	logic signed [31:0] tgt_q [4];
	logic [25:0]        tl_q, tot_q;
	in_t                in_q;
	logic [26:0]        rem_q;
	logic [AW-1:0]      quo_q, t_q, s_q;
	logic [63:0]        p_q;
	logic               neg_q;

	logic signed [31:0] ax_in;
	logic [16:0]        nmag;
	logic [32:0]        mul_a;
	logic [30:0]        mul_b;
	logic [AW-1:0]      alpha;
	logic [AW:0]        cb_b;
	logic signed [32:0] diff;
	logic [32:0]        dmag;
	logic [47:0]        scl_r;
	logic [31:0]        scl_m;
	logic signed [31:0] scl_v;
	logic [63:0]        lrp_r;
	logic [34:0]        lrp_d;
	logic signed [34:0] lrp_s;
	logic [26:0]        div_c;
	logic [25:0]        tl_new;

	function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
		input logic [30:0] lim);
		logic signed [32:0] m;
		m = $signed({2'b00, lim});
		if (33'(v) > m)       clamp_sym = m[31:0];
		else if (33'(v) < -m) clamp_sym = 32'(-m);
		else                  clamp_sym = v;
	endfunction

	always_comb begin
		case (cmd.axis)
			2'd0:    ax_in = in_q.pitch_in;
			2'd1:    ax_in = in_q.roll_in;
			2'd2:    ax_in = in_q.forward_in;
			default: ax_in = in_q.vertical_in;
		endcase
		if (ax_in > 32'sd65536 || ax_in < -32'sd65536) nmag = 17'h10000;
		else if (ax_in[31])                            nmag = 17'(-ax_in);
		else                                           nmag = ax_in[16:0];

		if (tot_q == '0)       alpha = ONE;
		else if (tl_q > tot_q) alpha = '0;
		else                   alpha = ONE - quo_q;
		cb_b = THREE - {alpha, 1'b0};

		diff = 33'(tgt_q[cmd.axis]) - 33'(cur_q[cmd.axis]);
		dmag = diff[32] ? 33'(-diff) : 33'(diff);

		case (cmd.op)
			OP_SCL_MUL: begin mul_a = 33'(nmag);  mul_b = lim_q[cmd.axis]; end
			OP_SQ_MUL:  begin mul_a = 33'(alpha); mul_b = 31'(alpha); end
			OP_CB_MUL:  begin mul_a = 33'(t_q);   mul_b = 31'(cb_b); end
			OP_LRP_MUL: begin mul_a = dmag;       mul_b = 31'(s_q); end
			default:    begin mul_a = '0;         mul_b = '0; end
		endcase

		scl_r = p_q[47:0] + 48'd32768;
		scl_m = {1'b0, scl_r[46:16]};
		scl_v = ax_in[31] ? -$signed(scl_m) : $signed(scl_m);

		lrp_r = (p_q + HALF) >> AF;
		lrp_d = lrp_r[34:0];
		lrp_s = 35'(cur_q[cmd.axis]) + (neg_q ? -$signed(lrp_d) : $signed(lrp_d));

		div_c  = (rem_q >= 27'(tot_q)) ? rem_q - 27'(tot_q) : rem_q;
		tl_new = tl_q - 26'(in_q.elapsed_us);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			gyro_q   <= 1'b0;
			lim_q[0] <= LIM_ROT_RST;
			lim_q[1] <= LIM_ROT_RST;
			lim_q[2] <= LIM_TRANS_RST;
			lim_q[3] <= LIM_TRANS_RST;
			for (int i = 0; i < 4; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
			end
			tl_q  <= '0;
			tot_q <= '0;
			ign_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_ENABLED: en_q     <= cfg_wdata[0];
					CFG_GYRO:    gyro_q   <= cfg_wdata[0];
					CFG_MAX_P:   lim_q[0] <= cfg_wdata;
					CFG_MAX_R:   lim_q[1] <= cfg_wdata;
					CFG_MAX_F:   lim_q[2] <= cfg_wdata;
					CFG_MAX_V:   lim_q[3] <= cfg_wdata;
					default:     en_q     <= en_q;
				endcase
			end
			case (cmd.op)
				OP_LOAD: ign_q <= !en_q;
				OP_ABS: begin
					if (gyro_q && in_q.continuous) begin
						tgt_q[0] <= in_q.pitch_in;
						tgt_q[1] <= in_q.roll_in;
						tgt_q[2] <= '0;
						tgt_q[3] <= '0;
					end else begin
						tgt_q[0] <= clamp_sym(in_q.pitch_in, lim_q[0]);
						tgt_q[1] <= clamp_sym(in_q.roll_in, lim_q[1]);
						tgt_q[2] <= clamp_sym(in_q.forward_in, lim_q[2]);
						tgt_q[3] <= clamp_sym(in_q.vertical_in, lim_q[3]);
					end
					tl_q  <= in_q.duration_us;
					tot_q <= in_q.duration_us;
				end
				// scaled value never exceeds its limit, so no clamp
				OP_SCL_WR: tgt_q[cmd.axis] <= (gyro_q && cmd.axis[1]) ? '0 : scl_v;
				OP_NORM_FIN: begin
					tl_q  <= (in_q.duration_us < MIN_DUR) ? MIN_DUR : in_q.duration_us;
					tot_q <= (in_q.duration_us < MIN_DUR) ? MIN_DUR : in_q.duration_us;
				end
				OP_ESTOP: begin
					for (int i = 0; i < 4; i++) tgt_q[i] <= cur_q[i];
					tl_q <= '0;
				end
				OP_SNAP: begin
					for (int i = 0; i < 4; i++) cur_q[i] <= tgt_q[i];
					tl_q <= '0;
				end
				OP_SUB: tl_q <= tl_new;
				OP_LRP_WR: begin
					if (lrp_s > 35'sd2147483647)       cur_q[cmd.axis] <= 32'h7fffffff;
					else if (lrp_s < -35'sd2147483648) cur_q[cmd.axis] <= 32'h80000000;
					else                               cur_q[cmd.axis] <= lrp_s[31:0];
				end
				default: tl_q <= tl_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= 64'(mul_a) * 64'(mul_b);
		case (cmd.op)
			OP_LOAD: in_q <= in_data;
			OP_SUB: begin
				rem_q <= 27'(tl_new);
				quo_q <= '0;
			end
			// one quotient bit a step, MSB first
			OP_DIV: begin
				quo_q <= {quo_q[AW-2:0], (rem_q >= 27'(tot_q))};
				rem_q <= {div_c[25:0], 1'b0};
			end
			OP_SQ_WR:   t_q <= p_q[AF +: AW];
			OP_CB_WR:   s_q <= p_q[AF +: AW];
			OP_LRP_MUL: neg_q <= diff[32];
			default:    neg_q <= neg_q;
		endcase
	end

	assign sts.ign     = ign_q;
	assign sts.func    = in_q.func;
	assign sts.tl_zero = (tl_q == '0);
	assign sts.expire  = (26'(in_q.elapsed_us) >= tl_q);

	assign res.cur_pitch    = cur_q[0];
	assign res.cur_roll     = cur_q[1];
	assign res.cur_forward  = cur_q[2];
	assign res.cur_vertical = cur_q[3];
	assign res.tgt_pitch    = tgt_q[0];
	assign res.tgt_roll     = tgt_q[1];
	assign res.tgt_forward  = tgt_q[2];
	assign res.tgt_vertical = tgt_q[3];
	assign res.moving       = (tl_q != '0);
	assign res.ignored      = ign_q;

endmodule
